// ===== hw/rtl/fcw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcw_pkg: shared types and constants of the falloff curve weight block
// Field widths, register indexes, curve codes and fixed-point constants.
// ----------------------------------------------------------------------------
package fcw_pkg;

    localparam int RadiusW  = 16;
    localparam int HalfW    = 8;
    localparam int ModeW    = 3;
    localparam int SlotW    = 9;
    localparam int WeightW  = 16;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int QuotW    = 15;   // quotient bits below the overflow check
    localparam int RadW     = 32;   // square root operand
    localparam int RootW    = 16;
    localparam int UnitStg  = 4;    // stages of the divider and of the root unit

    typedef logic [SlotW-1:0]    t_slot;
    typedef logic [WeightW-1:0]  t_weight;
    typedef logic [RadiusW-1:0]  t_radius;
    typedef logic [HalfW-1:0]    t_half;
    typedef logic [ModeW-1:0]    t_mode;
    typedef logic [QuotW-1:0]    t_quot;
    typedef logic [RadW-1:0]     t_rad;
    typedef logic [RootW-1:0]    t_root;
    typedef logic [UnitStg-1:0]  t_unit_adv;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_RADIUS       = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HALF_WIDTH   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FALLOFF_MODE = 2'd2;

    // Curve codes; the two unused codes act as linear
    localparam t_mode MODE_SMOOTH = 3'd0;
    localparam t_mode MODE_SPHERE = 3'd1;
    localparam t_mode MODE_ROOT   = 3'd2;
    localparam t_mode MODE_SHARP  = 3'd3;
    localparam t_mode MODE_LINEAR = 3'd4;
    localparam t_mode MODE_INV_SQ = 3'd5;

    localparam t_radius RADIUS_RST     = 16'd256;
    localparam t_half   HALF_WIDTH_RST = 8'd1;
    localparam t_mode   MODE_RST       = MODE_LINEAR;

    localparam t_half   MAX_HALF_WIDTH = 8'd255;

    localparam t_weight ONE_Q15 = 16'h8000;

endpackage

// ===== hw/rtl/fcw_in_if.sv =====
// ----------------------------------------------------------------------------
// fcw_in_if: slot channel
// Valid/ready channel that carries one table slot per transfer.
// ----------------------------------------------------------------------------
interface fcw_in_if import fcw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_slot slot_index;

    modport source (output valid, output slot_index, input ready);
    modport sink   (input valid, input slot_index, output ready);
endinterface

// ===== hw/rtl/fcw_out_if.sv =====
// ----------------------------------------------------------------------------
// fcw_out_if: weight channel
// Valid/ready channel that carries one shaped weight per transfer.
// ----------------------------------------------------------------------------
interface fcw_out_if import fcw_pkg::*; ();
    logic    valid;
    logic    ready;
    t_weight weight;
    logic    slot_error;

    modport source (output valid, output weight, output slot_error, input ready);
    modport sink   (input valid, input weight, input slot_error, output ready);
endinterface

// ===== hw/rtl/falloff_curve_weight.sv =====
// ----------------------------------------------------------------------------
// falloff_curve_weight: one tap of a feather falloff table
// Slot in, shaped Q1.15 closeness weight out, through a twelve-stage pipeline.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                         handshake
//   --------  ---------  ------------------------------  ----------------
//   i_in      in         slot_index[8:0]                 valid / ready
//   o_out     out        weight[15:0], slot_error        valid / ready
//   i_cfg_*   in         index[1:0], data[15:0]          write enable only
//
// One slot can transfer in every cycle while the output is not stalled.
// The depth is set by the four-stage divider (15 quotient bits) and the
// four-stage square root unit (16 root bits), plus entry, closeness, product
// and output stages.
// Reset clears every valid bit and loads radius 1.0, half-width 1, linear.
// A stage holds while the stage after it is full and stalled; empty stages
// fill up, so the input stays ready until the whole pipeline is full and the output is stalled.
// ----------------------------------------------------------------------------
module falloff_curve_weight import fcw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    fcw_in_if.sink              i_in,
    fcw_out_if.source           o_out
);

    // Stage map: 0 entry, 1-4 divider, 5 closeness, 6 products,
    // 7-10 root (smooth/sharp/inverse square/linear ride alongside), 11 output.
    localparam int NStg   = 12;
    localparam int DivLo  = 1;
    localparam int CloStg = DivLo + UnitStg;
    localparam int MulStg = CloStg + 1;
    localparam int SqLo   = MulStg + 1;
    localparam int OutStg = SqLo + UnitStg;

    // ---------------- configuration registers ----------------
    t_radius r_radius;
    t_half   r_half_width;
    t_mode   r_falloff_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= RADIUS_RST;
            r_half_width   <= HALF_WIDTH_RST;
            r_falloff_mode <= MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:       r_radius       <= i_cfg_data[RadiusW-1:0];
                CFG_HALF_WIDTH:   r_half_width   <= i_cfg_data[HalfW-1:0];
                CFG_FALLOFF_MODE: r_falloff_mode <= i_cfg_data[ModeW-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    logic [NStg-1:0] r_v;
    logic [NStg-1:0] r_err;
    logic [NStg-1:0] w_adv;

    // A stage takes new data when it is empty or its content moves on
    always_comb begin
        w_adv[NStg-1] = !r_v[NStg-1] || o_out.ready;
        for (int k = NStg - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign i_in.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NStg; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= (k == 0) ? i_in.valid : r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: slot check and tap distance ----------------
    t_half   w_hw;
    t_slot   w_hw_ext;
    logic    w_err;
    t_slot   w_dist_full;
    t_half   r_dist;

    always_comb begin
        w_hw        = (r_half_width > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : r_half_width;
        w_hw_ext    = {1'b0, w_hw};
        w_err       = i_in.slot_index > {w_hw, 1'b0};
        w_dist_full = (i_in.slot_index >= w_hw_ext) ? (i_in.slot_index - w_hw_ext)
                                                    : (w_hw_ext - i_in.slot_index);
    end

    // Error flag travels with the item through every stage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NStg; k++) begin
            if (w_adv[k]) begin
                r_err[k] <= (k == 0) ? w_err : r_err[k-1];
            end
        end
        if (w_adv[0]) begin
            r_dist <= w_dist_full[HalfW-1:0];
        end
    end

    // ---------------- stages 1-4: |d| / radius ----------------
    t_quot w_quot;
    logic  w_ovf;

    fcw_div u_div (
        .i_clk    (i_clk),
        .i_adv    (w_adv[DivLo +: UnitStg]),
        .i_dist   (r_dist),
        .i_radius (r_radius),
        .o_quot   (w_quot),
        .o_ovf    (w_ovf)
    );

    // ---------------- stage 5: linear closeness ----------------
    t_weight r_c5;

    always_ff @(posedge i_clk) begin
        if (w_adv[CloStg]) begin
            if (r_radius == '0) begin
                r_c5 <= ONE_Q15;
            end else if (w_ovf) begin
                r_c5 <= '0;       // offset at or beyond the radius
            end else begin
                r_c5 <= ONE_Q15 - {1'b0, w_quot};
            end
        end
    end

    // ---------------- stage 6: c*c and c*(2-c) ----------------
    logic [31:0] w_c2_full;
    logic [32:0] w_p_full;
    t_weight     r_c6;
    logic [30:0] r_c2;
    logic [30:0] r_p;

    assign w_c2_full = 32'(r_c5) * 32'(r_c5);
    assign w_p_full  = 33'(r_c5) * 33'(17'h10000 - {1'b0, r_c5});

    always_ff @(posedge i_clk) begin
        if (w_adv[MulStg]) begin
            r_c6 <= r_c5;
            r_c2 <= w_c2_full[30:0];
            r_p  <= w_p_full[30:0];
        end
    end

    // ---------------- stages 7-10: square root curves ----------------
    t_rad  w_radicand;
    t_root w_root;

    assign w_radicand = (r_falloff_mode == MODE_SPHERE) ? {1'b0, r_p}
                                                       : {1'b0, r_c6, 15'h0000};

    fcw_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_adv      (w_adv[SqLo +: UnitStg]),
        .i_radicand (w_radicand),
        .o_root     (w_root)
    );

    // ---------------- stage 7 side path: polynomial curves ----------------
    logic [47:0] w_sm_full;
    logic [47:0] w_sm_rnd;
    logic [31:0] w_sharp_rnd;
    logic [31:0] w_inv_rnd;
    t_weight     w_poly;
    t_weight     r_poly [UnitStg];

    always_comb begin
        // smooth: c^2 * (3 - 2c), rounded back to Q1.15
        w_sm_full   = 48'(r_c2) * 48'(17'h18000 - {r_c6, 1'b0});
        w_sm_rnd    = w_sm_full + 48'h0000_2000_0000;
        w_sharp_rnd = {1'b0, r_c2} + 32'h0000_4000;
        w_inv_rnd   = {1'b0, r_p} + 32'h0000_4000;
        case (r_falloff_mode)
            MODE_SMOOTH: w_poly = w_sm_rnd[45:30];
            MODE_SHARP:  w_poly = w_sharp_rnd[30:15];
            MODE_INV_SQ: w_poly = w_inv_rnd[30:15];
            default:     w_poly = r_c6;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < UnitStg; k++) begin
            if (w_adv[SqLo + k]) begin
                r_poly[k] <= (k == 0) ? w_poly : r_poly[k-1];
            end
        end
    end

    // ---------------- stage 11: output register ----------------
    t_weight r_weight;

    always_ff @(posedge i_clk) begin
        if (w_adv[OutStg]) begin
            if (r_err[OutStg-1]) begin
                r_weight <= '0;
            end else begin
                case (r_falloff_mode) inside
                    MODE_SPHERE, MODE_ROOT: r_weight <= w_root;
                    default:                r_weight <= r_poly[UnitStg-1];
                endcase
            end
        end
    end

    assign o_out.valid      = r_v[OutStg];
    assign o_out.weight     = r_weight;
    assign o_out.slot_error = r_err[OutStg];

    // ---------------- checks ----------------
    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v[0])
        else $error("transferred slot did not enter the pipeline");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.slot_error |-> o_out.weight == '0)
        else $error("slot beyond the table gave a nonzero weight");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.weight <= ONE_Q15)
        else $error("weight above 1.0");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.slot_error && r_radius == '0 &&
        r_falloff_mode == MODE_LINEAR |-> o_out.weight == ONE_Q15)
        else $error("zero radius did not give full weight");

endmodule

// ===== hw/rtl/fcw_div.sv =====
// ----------------------------------------------------------------------------
// fcw_div: pipelined restoring divider
// Computes (dist << 23) / radius in four stages; flags quotients of 2^15 and up.
// ----------------------------------------------------------------------------
module fcw_div import fcw_pkg::*; (
    input  logic      i_clk,
    input  t_unit_adv i_adv,
    input  t_half     i_dist,
    input  t_radius   i_radius,
    output t_quot     o_quot,
    output logic      o_ovf
);

    typedef struct packed {
        t_radius rem;
        t_quot   quot;
    } t_div_st;

    function automatic t_div_st div_step(t_div_st s, t_radius r);
        logic [RadiusW:0] t;
        t_div_st          o;
        t = {s.rem, 1'b0};
        if (t >= {1'b0, r}) begin
            t      = t - {1'b0, r};
            o.quot = {s.quot[QuotW-2:0], 1'b1};
        end else begin
            o.quot = {s.quot[QuotW-2:0], 1'b0};
        end
        o.rem = t[RadiusW-1:0];
        return o;
    endfunction

    t_div_st r_st  [UnitStg];
    logic    r_ovf [UnitStg];
    t_div_st n_st  [UnitStg];

    // First stage: overflow check plus three quotient bits, then four per stage
    always_comb begin
        t_div_st s;
        s.rem  = {i_dist, 8'h00};
        s.quot = '0;
        for (int i = 0; i < 3; i++) begin
            s = div_step(s, i_radius);
        end
        n_st[0] = s;
        for (int k = 1; k < UnitStg; k++) begin
            s = r_st[k-1];
            for (int i = 0; i < 4; i++) begin
                s = div_step(s, i_radius);
            end
            n_st[k] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_st[0]  <= n_st[0];
            r_ovf[0] <= ({i_dist, 8'h00} >= i_radius);
        end
        for (int k = 1; k < UnitStg; k++) begin
            if (i_adv[k]) begin
                r_st[k]  <= n_st[k];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_st[UnitStg-1].quot;
    assign o_ovf  = r_ovf[UnitStg-1];

endmodule

// ===== hw/rtl/fcw_sqrt.sv =====
// ----------------------------------------------------------------------------
// fcw_sqrt: pipelined integer square root
// Digit-by-digit root of a 32-bit operand, four result bits per stage.
// ----------------------------------------------------------------------------
module fcw_sqrt import fcw_pkg::*; (
    input  logic      i_clk,
    input  t_unit_adv i_adv,
    input  t_rad      i_radicand,
    output t_root     o_root
);

    typedef struct packed {
        t_rad           x;
        t_root          root;
        logic [RootW:0] rem;
    } t_sq_st;

    function automatic t_sq_st sq_step(t_sq_st s);
        logic [RootW+2:0] w;
        logic [RootW+2:0] trial;
        t_sq_st           o;
        w     = {s.rem, s.x[RadW-1:RadW-2]};
        trial = {1'b0, s.root, 2'b01};
        o.x   = {s.x[RadW-3:0], 2'b00};
        if (w >= trial) begin
            w      = w - trial;
            o.root = {s.root[RootW-2:0], 1'b1};
        end else begin
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        o.rem = w[RootW:0];
        return o;
    endfunction

    t_sq_st r_st [UnitStg];
    t_sq_st n_st [UnitStg];

    always_comb begin
        t_sq_st s;
        for (int k = 0; k < UnitStg; k++) begin
            if (k == 0) begin
                s.x    = i_radicand;
                s.root = '0;
                s.rem  = '0;
            end else begin
                s = r_st[k-1];
            end
            for (int i = 0; i < 4; i++) begin
                s = sq_step(s);
            end
            n_st[k] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < UnitStg; k++) begin
            if (i_adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = r_st[UnitStg-1].root;

endmodule
